// ===== sv/etk_pkg.sv =====
`default_nettype none

package etk_pkg;

  localparam logic [4:0] K_ERR    = 5'd0;
  localparam logic [4:0] K_LT     = 5'd1;
  localparam logic [4:0] K_LE     = 5'd2;
  localparam logic [4:0] K_GT     = 5'd3;
  localparam logic [4:0] K_GE     = 5'd4;
  localparam logic [4:0] K_EQ     = 5'd5;
  localparam logic [4:0] K_NE     = 5'd6;
  localparam logic [4:0] K_MINUS  = 5'd7;
  localparam logic [4:0] K_PLUS   = 5'd8;
  localparam logic [4:0] K_MUL    = 5'd9;
  localparam logic [4:0] K_AND    = 5'd10;
  localparam logic [4:0] K_DIV    = 5'd11;
  localparam logic [4:0] K_COLON  = 5'd12;
  localparam logic [4:0] K_QUEST  = 5'd13;
  localparam logic [4:0] K_LPAREN = 5'd14;
  localparam logic [4:0] K_RPAREN = 5'd15;
  localparam logic [4:0] K_STR    = 5'd16;
  localparam logic [4:0] K_INT    = 5'd17;
  localparam logic [4:0] K_REAL   = 5'd18;
  localparam logic [4:0] K_IDENT  = 5'd19;
  localparam logic [4:0] K_END    = 5'd20;

  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [7:0]  length;
    logic [31:0] row;
    logic        too_long;
    logic        last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) || b[7];
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

`default_nettype wire

// ===== sv/etk_scan_core.sv =====
`default_nettype none

module etk_scan_core #(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int POSITION_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            fire,
  input  wire logic [7:0]      text_byte,
  input  wire logic            end_of_text,
  output etk_pkg::token_t      res0,
  output etk_pkg::token_t      res1,
  output logic [1:0]           res_count
);
  import etk_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 2);
  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN);
  localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
  localparam logic [LEN_BITS-1:0] LEN_TWO = LEN_BITS'(2);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_LT    = 3'd1;
  localparam logic [2:0] M_GT    = 3'd2;
  localparam logic [2:0] M_BANG  = 3'd3;
  localparam logic [2:0] M_INT   = 3'd4;
  localparam logic [2:0] M_REAL  = 3'd5;
  localparam logic [2:0] M_IDENT = 3'd6;
  localparam logic [2:0] M_STR   = 3'd7;

  logic [2:0]               mode, mode_next;
  logic [POSITION_BITS-1:0] pending_start, start_next;
  logic [LEN_BITS-1:0]      pending_length, len_next;
  logic [POSITION_BITS-1:0] pending_row, prow_next;
  logic [POSITION_BITS-1:0] byte_offset, offset_next;
  logic [POSITION_BITS-1:0] row_count, row_next;
  logic                     ended, ended_next;
  logic [7:0]               dp_char;

  logic     flush_en, fresh_en, do_fresh;
  logic [4:0] fresh_kind;
  token_t   flush_tok, fresh_tok;

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
    pos_inc = (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic token_t make_tok(input logic [4:0] kind,
                                      input logic [POSITION_BITS-1:0] start,
                                      input logic [LEN_BITS-1:0] len,
                                      input logic [POSITION_BITS-1:0] row);
    token_t t;
    t.kind     = kind;
    t.start    = 32'(start);
    t.length   = 8'((len > LEN_MAX) ? LEN_MAX : len);
    t.row      = 32'(row);
    t.too_long = len > LEN_MAX;
    t.last     = 1'b0;
    make_tok = t;
  endfunction

  function automatic logic [4:0] mode_kind(input logic [2:0] m);
    logic [4:0] k;
    unique case (m)
      M_LT:    k = K_LT;
      M_GT:    k = K_GT;
      M_INT:   k = K_INT;
      M_REAL:  k = K_REAL;
      M_IDENT: k = K_IDENT;
      M_STR:   k = K_STR;
      default: k = K_ERR;
    endcase
    mode_kind = k;
  endfunction

  always_comb begin
    mode_next   = mode;
    start_next  = pending_start;
    len_next    = pending_length;
    prow_next   = pending_row;
    offset_next = byte_offset;
    row_next    = row_count;
    ended_next  = ended;
    flush_en    = 1'b0;
    fresh_en    = 1'b0;
    do_fresh    = 1'b0;
    fresh_kind  = K_ERR;
    flush_tok   = make_tok(mode_kind(mode), pending_start, pending_length, pending_row);
    fresh_tok   = make_tok(K_END, byte_offset, '0, row_count);

    if (fire) begin
      if (end_of_text) begin
        flush_en   = !ended && (mode != M_IDLE);
        fresh_en   = 1'b1;
        mode_next  = M_IDLE;
        ended_next = 1'b1;
      end else if (!ended) begin
        unique case (mode) inside
          M_LT: begin
            if (text_byte == CH_EQ || text_byte == CH_GT) begin
              flush_en  = 1'b1;
              flush_tok = make_tok((text_byte == CH_EQ) ? K_LE : K_NE,
                                   pending_start, LEN_TWO, pending_row);
              mode_next = M_IDLE;
            end else begin
              flush_en = 1'b1;
              do_fresh = 1'b1;
            end
          end
          M_GT, M_BANG: begin
            if (text_byte == CH_EQ) begin
              flush_en  = 1'b1;
              flush_tok = make_tok((mode == M_GT) ? K_GE : K_NE,
                                   pending_start, LEN_TWO, pending_row);
              mode_next = M_IDLE;
            end else begin
              flush_en = 1'b1;
              do_fresh = 1'b1;
            end
          end
          M_INT: begin
            if (is_digit(text_byte) || text_byte == dp_char || is_alpha(text_byte)) begin
              if (pending_length <= LEN_MAX) len_next = pending_length + 1'b1;
              if (!is_digit(text_byte)) begin
                mode_next = (text_byte == dp_char) ? M_REAL : M_IDENT;
              end
            end else begin
              flush_en = 1'b1;
              do_fresh = 1'b1;
            end
          end
          M_REAL: begin
            if (is_digit(text_byte)) begin
              if (pending_length <= LEN_MAX) len_next = pending_length + 1'b1;
            end else begin
              flush_en = 1'b1;
              do_fresh = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_digit(text_byte) || is_alpha(text_byte) || text_byte == CH_UNDER) begin
              if (pending_length <= LEN_MAX) len_next = pending_length + 1'b1;
            end else begin
              flush_en = 1'b1;
              do_fresh = 1'b1;
            end
          end
          M_STR: begin
            if (text_byte == CH_QUOTE) begin
              flush_en  = 1'b1;
              mode_next = M_IDLE;
            end else if (pending_length <= LEN_MAX) begin
              len_next = pending_length + 1'b1;
            end
          end
          default: do_fresh = 1'b1;
        endcase

        if (do_fresh) begin
          mode_next = M_IDLE;
          if (!is_space(text_byte)) begin
            unique case (text_byte) inside
              CH_LT, CH_GT, CH_BANG: begin
                mode_next  = (text_byte == CH_LT) ? M_LT :
                             (text_byte == CH_GT) ? M_GT : M_BANG;
                start_next = byte_offset;
                len_next   = LEN_ONE;
                prow_next  = row_count;
              end
              CH_QUOTE: begin
                mode_next  = M_STR;
                start_next = pos_inc(byte_offset);
                len_next   = '0;
                prow_next  = row_count;
              end
              CH_EQ:     begin fresh_en = 1'b1; fresh_kind = K_EQ;     end
              CH_MINUS:  begin fresh_en = 1'b1; fresh_kind = K_MINUS;  end
              CH_PLUS:   begin fresh_en = 1'b1; fresh_kind = K_PLUS;   end
              CH_STAR:   begin fresh_en = 1'b1; fresh_kind = K_MUL;    end
              CH_AMP:    begin fresh_en = 1'b1; fresh_kind = K_AND;    end
              CH_SLASH:  begin fresh_en = 1'b1; fresh_kind = K_DIV;    end
              CH_COLON:  begin fresh_en = 1'b1; fresh_kind = K_COLON;  end
              CH_QUEST:  begin fresh_en = 1'b1; fresh_kind = K_QUEST;  end
              CH_LPAREN: begin fresh_en = 1'b1; fresh_kind = K_LPAREN; end
              CH_RPAREN: begin fresh_en = 1'b1; fresh_kind = K_RPAREN; end
              default: begin
                if (is_digit(text_byte) || is_alpha(text_byte)) begin
                  mode_next  = is_digit(text_byte) ? M_INT : M_IDENT;
                  start_next = byte_offset;
                  len_next   = LEN_ONE;
                  prow_next  = row_count;
                end else begin
                  fresh_en   = 1'b1;
                  fresh_kind = K_ERR;
                end
              end
            endcase
          end
          fresh_tok = make_tok(fresh_kind, byte_offset, LEN_ONE, row_count);
        end

        if (text_byte == CH_NEWLINE) row_next = pos_inc(row_count);
        offset_next = pos_inc(byte_offset);
      end
    end
  end

  // pack results in order: closed token first, then the one the byte forms
  always_comb begin
    res0 = flush_en ? flush_tok : fresh_tok;
    res1 = fresh_tok;
    res_count = 2'(flush_en) + 2'(fresh_en);
    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      byte_offset <= '0;
      row_count   <= '0;
      ended       <= 1'b0;
      dp_char     <= CH_PERIOD;
    end else begin
      mode        <= mode_next;
      byte_offset <= offset_next;
      row_count   <= row_next;
      ended       <= ended_next;
      if (cfg_write) dp_char <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_start  <= '0;
      pending_length <= '0;
      pending_row    <= '0;
    end else begin
      pending_start  <= start_next;
      pending_length <= len_next;
      pending_row    <= prow_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/etk_out_queue.sv =====
`default_nettype none

module etk_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [1:0]       push_count,
  input  wire etk_pkg::token_t  push_tok0,
  input  wire etk_pkg::token_t  push_tok1,
  output logic                  can_push,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output etk_pkg::token_t       head
);
  import etk_pkg::*;

  logic [1:0] count;
  token_t     slot0, slot1;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign head      = slot0;
  // a push only lands on an empty queue (after this cycle's pop)
  assign can_push  = !rst && ((count == 2'd0) || ((count == 2'd1) && out_ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= push_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= push_tok0;
      slot1 <= push_tok1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/expression_token_scanner.sv =====
`default_nettype none

// channel   direction  handshake            payload
// input     in         in_valid/in_ready    text_byte, end_of_text
// output    out        out_valid/out_ready  token_kind .. last_of_run
// config    in         cfg_write            cfg_data (decimal point byte)
//
// One word per cycle when each word yields at most one token and out_ready
// stays high; a word that closes a token and forms another holds off the
// next word while the single result port drains a two-entry token queue.
// Synchronous reset; clears scan state, counters and the queue, and sets
// the decimal point byte to '.'. in_ready is low in reset and drops while
// the queue cannot take a new word's tokens.

module expression_token_scanner #(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       token_kind,
  output logic [31:0]      token_start,
  output logic [7:0]       token_length,
  output logic [31:0]      token_row,
  output logic             too_long,
  output logic             last_of_run
);
  import etk_pkg::*;

  logic       fire;
  token_t     res0, res1, head;
  logic [1:0] res_count;

  assign fire = in_valid && in_ready;

  etk_scan_core #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .fire        (fire),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .res0        (res0),
    .res1        (res1),
    .res_count   (res_count)
  );

  etk_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_count (res_count),
    .push_tok0  (res0),
    .push_tok1  (res1),
    .can_push   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign token_row    = head.row;
  assign too_long     = head.too_long;
  assign last_of_run  = head.last;

endmodule

`default_nettype wire
